>>> rtl/core/fcb_pkg.sv
// ----------------------------------------------------------------------------
// fcb_pkg
// Shared types, register indexes and constants of the format converting blit.
// ----------------------------------------------------------------------------
package fcb_pkg;

  localparam int MAX_DIMENSION = 4096;
  localparam int PALETTE_DEPTH = 256;
  localparam int PAL_AW        = $clog2(PALETTE_DEPTH);

  localparam logic [1:0] REG_MODE        = 2'd0;
  localparam logic [1:0] REG_PIXEL_BYTES = 2'd1;
  localparam logic [1:0] REG_STRIDE      = 2'd2;

  localparam logic [2:0] MODE_COPY   = 3'd0;
  localparam logic [2:0] MODE_RGB555 = 3'd1;
  localparam logic [2:0] MODE_RGB565 = 3'd2;
  localparam logic [2:0] MODE_PAL8   = 3'd3;
  localparam logic [2:0] MODE_NONE   = 3'd4;

  localparam logic [1:0] KIND_PAL_WRITE = 2'd0;
  localparam logic [1:0] KIND_START     = 2'd1;
  localparam logic [1:0] KIND_PIXEL     = 2'd2;

  localparam logic OUT_KIND_SIZE  = 1'b0;
  localparam logic OUT_KIND_PIXEL = 1'b1;

  typedef struct packed {
    logic [2:0]  conversion_mode;
    logic [2:0]  pixel_bytes;
    logic [15:0] dest_row_stride;
  } cfg_t;

  typedef struct packed {
    logic        valid;
    logic        is_pixel;
    logic [2:0]  mode;
    logic [2:0]  bpp;
    logic [31:0] px;
    logic [29:0] yprod;
    logic [16:0] xterm;
    logic [12:0] cw;
    logic [12:0] ch;
    logic        last;
  } stage_t;

endpackage

>>> rtl/core/fcb_if.sv
// ----------------------------------------------------------------------------
// fcb_in_if / fcb_out_if
// Valid/ready channels carrying blit input items and result items.
// ----------------------------------------------------------------------------
interface fcb_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] pixel_in;
  logic [7:0]  palette_slot;
  logic [11:0] dest_x;
  logic [11:0] dest_y;
  logic [12:0] dest_width;
  logic [12:0] dest_height;
  logic [11:0] source_x;
  logic [11:0] source_y;
  logic [12:0] source_width;
  logic [12:0] source_height;

  modport source (
    output valid, kind, pixel_in, palette_slot, dest_x, dest_y, dest_width,
           dest_height, source_x, source_y, source_width, source_height,
    input  ready
  );
  modport sink (
    input  valid, kind, pixel_in, palette_slot, dest_x, dest_y, dest_width,
           dest_height, source_x, source_y, source_width, source_height,
    output ready
  );
endinterface

interface fcb_out_if;
  logic        valid;
  logic        ready;
  logic        out_kind;
  logic [31:0] byte_offset;
  logic [31:0] pixel_out;
  logic [2:0]  write_bytes;
  logic [12:0] clip_width;
  logic [12:0] clip_height;
  logic        last_of_blit;

  modport source (
    output valid, out_kind, byte_offset, pixel_out, write_bytes, clip_width,
           clip_height, last_of_blit,
    input  ready
  );
  modport sink (
    input  valid, out_kind, byte_offset, pixel_out, write_bytes, clip_width,
           clip_height, last_of_blit,
    output ready
  );
endinterface

>>> rtl/core/fcb_regs.sv
// ----------------------------------------------------------------------------
// fcb_regs
// APB configuration registers: conversion mode, pixel bytes, row stride.
// ----------------------------------------------------------------------------
module fcb_regs (
  input  logic          clk,
  input  logic          rst,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [3:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  output fcb_pkg::cfg_t cfg
);

  logic       wr;
  logic [1:0] idx;

  assign pready = 1'b1;
  assign idx    = paddr[3:2];
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.conversion_mode <= fcb_pkg::MODE_NONE;
      cfg.pixel_bytes     <= 3'd4;
      cfg.dest_row_stride <= '0;
    end else if (wr) begin
      unique case (idx)
        fcb_pkg::REG_MODE:        cfg.conversion_mode <= pwdata[2:0];
        fcb_pkg::REG_PIXEL_BYTES: cfg.pixel_bytes     <= pwdata[2:0];
        fcb_pkg::REG_STRIDE:      cfg.dest_row_stride <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      fcb_pkg::REG_MODE:        prdata = {29'd0, cfg.conversion_mode};
      fcb_pkg::REG_PIXEL_BYTES: prdata = {29'd0, cfg.pixel_bytes};
      fcb_pkg::REG_STRIDE:      prdata = {16'd0, cfg.dest_row_stride};
      default:                  prdata = '0;
    endcase
  end

endmodule

>>> rtl/core/fcb_palette.sv
// ----------------------------------------------------------------------------
// fcb_palette
// Palette memory, one write port and one registered read port.
// ----------------------------------------------------------------------------
module fcb_palette (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [fcb_pkg::PAL_AW-1:0] wr_addr,
  input  logic [23:0]                wr_data,
  input  logic                       rd_en,
  input  logic [fcb_pkg::PAL_AW-1:0] rd_addr,
  output logic [23:0]                rd_data
);

  logic [23:0] mem [fcb_pkg::PALETTE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/core/fcb_front.sv
// ----------------------------------------------------------------------------
// fcb_front
// Item decode, rectangle clip, raster counters and address product stage.
// ----------------------------------------------------------------------------
module fcb_front (
  input  logic            clk,
  input  logic            rst,
  input  fcb_pkg::cfg_t   cfg,
  input  logic            advance,
  fcb_in_if.sink          in_ch,
  output fcb_pkg::stage_t s1
);

  function automatic logic [12:0] clip_extent(input logic [12:0] size,
                                              input logic [11:0] start);
    logic [12:0] d;
    d = (size > {1'b0, start}) ? size - {1'b0, start} : '0;
    if (17'(d) > 17'(fcb_pkg::MAX_DIMENSION)) begin
      d = 13'(fcb_pkg::MAX_DIMENSION);
    end
    return d;
  endfunction

  logic        active;
  logic [12:0] col;
  logic [12:0] row;
  logic [12:0] cw;
  logic [12:0] ch;
  logic [11:0] ox;
  logic [11:0] oy;

  logic        accept;
  logic [2:0]  bpp;
  logic [12:0] wd, hd, ws, hs, w, h;
  logic [13:0] col_inc, row_inc;
  logic        col_end, row_end, last;
  logic [13:0] y_sum, x_sum;
  logic [29:0] yprod;
  logic [16:0] xterm;

  assign in_ch.ready = advance;
  assign accept      = in_ch.valid && advance;

  always_comb begin
    if (cfg.conversion_mode == fcb_pkg::MODE_COPY) begin
      if (cfg.pixel_bytes == 3'd0) begin
        bpp = 3'd1;
      end else if (cfg.pixel_bytes > 3'd4) begin
        bpp = 3'd4;
      end else begin
        bpp = cfg.pixel_bytes;
      end
    end else begin
      bpp = 3'd4;
    end
  end

  always_comb begin
    wd = clip_extent(in_ch.dest_width, in_ch.dest_x);
    hd = clip_extent(in_ch.dest_height, in_ch.dest_y);
    ws = clip_extent(in_ch.source_width, in_ch.source_x);
    hs = clip_extent(in_ch.source_height, in_ch.source_y);
    w  = (ws < wd) ? ws : wd;
    h  = (hs < hd) ? hs : hd;
    if (cfg.conversion_mode > fcb_pkg::MODE_PAL8) begin
      w = '0;
      h = '0;
    end
  end

  assign col_inc = {1'b0, col} + 14'd1;
  assign row_inc = {1'b0, row} + 14'd1;
  assign col_end = col_inc >= {1'b0, cw};
  assign row_end = row_inc >= {1'b0, ch};
  assign last    = col_end && row_end;
  assign y_sum   = 14'(oy) + 14'(row);
  assign x_sum   = 14'(ox) + 14'(col);
  assign yprod   = 30'(y_sum) * 30'(cfg.dest_row_stride);
  assign xterm   = 17'(x_sum) * 17'(bpp);

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      col    <= '0;
      row    <= '0;
      cw     <= '0;
      ch     <= '0;
      ox     <= '0;
      oy     <= '0;
    end else if (accept) begin
      if (in_ch.kind == fcb_pkg::KIND_START) begin
        cw     <= w;
        ch     <= h;
        ox     <= in_ch.dest_x;
        oy     <= in_ch.dest_y;
        col    <= '0;
        row    <= '0;
        active <= (w != '0) && (h != '0);
      end else if (in_ch.kind == fcb_pkg::KIND_PIXEL && active) begin
        if (last) begin
          active <= 1'b0;
          col    <= '0;
          row    <= '0;
        end else if (col_end) begin
          col <= '0;
          row <= row_inc[12:0];
        end else begin
          col <= col_inc[12:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid <= 1'b0;
    end else if (advance) begin
      s1.valid <= accept && ((in_ch.kind == fcb_pkg::KIND_START) ||
                             (in_ch.kind == fcb_pkg::KIND_PIXEL && active));
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1.mode <= cfg.conversion_mode;
      s1.bpp  <= bpp;
      s1.px   <= in_ch.pixel_in;
      if (in_ch.kind == fcb_pkg::KIND_START) begin
        s1.is_pixel <= 1'b0;
        s1.yprod    <= '0;
        s1.xterm    <= '0;
        s1.cw       <= w;
        s1.ch       <= h;
        s1.last     <= 1'b0;
      end else begin
        s1.is_pixel <= 1'b1;
        s1.yprod    <= yprod;
        s1.xterm    <= xterm;
        s1.cw       <= cw;
        s1.ch       <= ch;
        s1.last     <= last;
      end
    end
  end

endmodule

>>> rtl/core/fcb_back.sv
// ----------------------------------------------------------------------------
// fcb_back
// Pixel conversion, offset sum and result output register.
// ----------------------------------------------------------------------------
module fcb_back (
  input  logic            clk,
  input  logic            rst,
  input  fcb_pkg::stage_t s1,
  input  logic [23:0]     pal_data,
  output logic            advance,
  fcb_out_if.source       out_ch
);

  function automatic logic [7:0] widen5(input logic [4:0] v);
    return {v, v[4:2]};
  endfunction

  logic [15:0] c;
  logic [31:0] conv;

  assign advance = !out_ch.valid || out_ch.ready;
  assign c       = s1.px[15:0];

  always_comb begin
    unique case (s1.mode)
      fcb_pkg::MODE_RGB555:
        conv = {8'hFF, widen5(c[14:10]), widen5(c[9:5]), widen5(c[4:0])};
      fcb_pkg::MODE_RGB565:
        conv = {8'hFF, widen5(c[15:11]), c[10:5], c[10:9], widen5(c[4:0])};
      fcb_pkg::MODE_PAL8:
        conv = {8'hFF, pal_data};
      default: begin
        unique case (s1.bpp)
          3'd1:    conv = {24'd0, s1.px[7:0]};
          3'd2:    conv = {16'd0, s1.px[15:0]};
          3'd3:    conv = {8'd0, s1.px[23:0]};
          default: conv = s1.px;
        endcase
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (advance) begin
      out_ch.valid <= s1.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1.valid) begin
      out_ch.out_kind     <= s1.is_pixel ? fcb_pkg::OUT_KIND_PIXEL
                                         : fcb_pkg::OUT_KIND_SIZE;
      out_ch.byte_offset  <= 32'(s1.yprod) + 32'(s1.xterm);
      out_ch.pixel_out    <= s1.is_pixel ? conv : '0;
      out_ch.write_bytes  <= s1.bpp;
      out_ch.clip_width   <= s1.cw;
      out_ch.clip_height  <= s1.ch;
      out_ch.last_of_blit <= s1.last;
    end
  end

endmodule

>>> rtl/core/format_converting_blit.sv
// ----------------------------------------------------------------------------
// format_converting_blit
// Blitter back end: clips a rectangle copy and converts source pixels.
// ----------------------------------------------------------------------------
// Takes one item per clock while the output channel is not stalled. Its result
// passes the first register stage, which holds the decoded item, the row-stride
// product and the palette memory read, and then the output register, which
// takes the converted pixel and the offset sum. Palette writes, unknown kinds
// and pixels outside a blit give no result. While a result waits on the output
// channel both stages hold and the input side stalls.
module format_converting_blit (
  input  logic        clk,
  input  logic        rst,
  fcb_in_if.sink      in_ch,
  fcb_out_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  fcb_pkg::cfg_t   cfg;
  fcb_pkg::stage_t s1;
  logic            advance;
  logic            accept;
  logic [23:0]     pal_data;

  assign accept = in_ch.valid && advance;

  fcb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  fcb_palette u_palette (
    .clk     (clk),
    .wr_en   (accept && in_ch.kind == fcb_pkg::KIND_PAL_WRITE),
    .wr_addr (in_ch.palette_slot),
    .wr_data (in_ch.pixel_in[23:0]),
    .rd_en   (accept),
    .rd_addr (in_ch.pixel_in[7:0]),
    .rd_data (pal_data)
  );

  fcb_front u_front (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .advance (advance),
    .in_ch   (in_ch),
    .s1      (s1)
  );

  fcb_back u_back (
    .clk      (clk),
    .rst      (rst),
    .s1       (s1),
    .pal_data (pal_data),
    .advance  (advance),
    .out_ch   (out_ch)
  );

endmodule
